// File: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL of the ordered id list engine.
// Both macros expect a clock named i_clk and an active-low reset i_rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define OILE_ASSERT(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define OILE_ASSERT_NEXT(name, trig, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

// File: hw/rtl/oile_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oile_pkg
// Field widths, operation codes and the cell command type of the ordered
// id list engine.
// ---------------------------------------------------------------------------
package oile_pkg;

    // Fixed widths of the request and response fields.
    localparam int OP_W    = 4;
    localparam int POS_W   = 4;
    localparam int ID_IN_W = 32;
    localparam int CNT_O_W = 5;

    // Operation codes carried in the opcode field.
    localparam logic [OP_W-1:0] OP_INSERT        = 4'd0;
    localparam logic [OP_W-1:0] OP_APPEND        = 4'd1;
    localparam logic [OP_W-1:0] OP_APPEND_ABSENT = 4'd2;
    localparam logic [OP_W-1:0] OP_INSERT_ABSENT = 4'd3;
    localparam logic [OP_W-1:0] OP_REMOVE_TAIL   = 4'd4;
    localparam logic [OP_W-1:0] OP_DELETE        = 4'd5;
    localparam logic [OP_W-1:0] OP_INSERT_ONLY   = 4'd6;
    localparam logic [OP_W-1:0] OP_QUERY_TAIL    = 4'd7;
    localparam logic [OP_W-1:0] OP_CLEAR         = 4'd8;

    // What every cell of the chain does in a cycle.
    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_SCAN,
        ACT_SWAP,
        ACT_INSERT,
        ACT_DELETE
    } t_cell_act;

    // Command broadcast from the sequencer to the cells.
    typedef struct packed {
        t_cell_act act;
        logic      phase;
    } t_cell_cmd;

endpackage

// File: hw/rtl/oile_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oile_req_if
// Request channel of the list engine: one list operation per request.
// ---------------------------------------------------------------------------
interface oile_req_if;
    logic                         valid;
    logic                         ready;
    logic [oile_pkg::OP_W-1:0]    opcode;
    logic [oile_pkg::POS_W-1:0]   position;
    logic [oile_pkg::ID_IN_W-1:0] id_value;

    modport source (output valid, opcode, position, id_value, input ready);
    modport sink   (input valid, opcode, position, id_value, output ready);
endinterface

// File: hw/rtl/oile_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oile_rsp_if
// Response channel of the list engine: one status response per operation.
// ---------------------------------------------------------------------------
interface oile_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         found;
    logic                         changed;
    logic                         full_error;
    logic [oile_pkg::CNT_O_W-1:0] entry_count;

    modport source (output valid, found, changed, full_error, entry_count, input ready);
    modport sink   (input valid, found, changed, full_error, entry_count, output ready);
endinterface

// File: hw/rtl/oile_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// oile_cell
// One list slot: holds an id and a live flag, compares against the
// operation id and trades contents with its neighbors.
// ---------------------------------------------------------------------------
module oile_cell #(
    parameter int ID_BITS = 32,
    parameter int PW      = 5,
    parameter int IDX     = 0
) (
    input  logic                 i_clk,
    input  oile_pkg::t_cell_cmd  i_cmd,
    input  logic [PW-1:0]        i_pos,
    input  logic [PW-1:0]        i_num,
    input  logic [ID_BITS-1:0]   i_id,
    input  logic [ID_BITS-1:0]   i_prev_entry,
    input  logic                 i_prev_live,
    input  logic [ID_BITS-1:0]   i_next_entry,
    input  logic                 i_next_live,
    output logic [ID_BITS-1:0]   o_entry,
    output logic                 o_live,
    output logic                 o_hit_tail,
    output logic                 o_hit_at
);
    import oile_pkg::*;

    localparam logic [PW-1:0] MY    = PW'(IDX);
    localparam logic [PW-1:0] MY_P1 = PW'(IDX + 1);
    localparam logic          PAR   = ((IDX % 2) == 1);

    logic [ID_BITS-1:0] r_entry;
    logic               r_live;
    logic [ID_BITS-1:0] n_entry;
    logic               n_live;
    logic               w_match;
    logic               w_in_list;

    // Local compare against the operation id and the list bounds.
    assign w_match    = (r_entry == i_id);
    assign w_in_list  = (MY < i_num);
    assign o_hit_tail = w_match && w_in_list && (MY >= i_pos);
    assign o_hit_at   = w_match && w_in_list && (MY == i_pos);
    assign o_entry    = r_entry;
    assign o_live     = r_live;

    // Next contents of the slot.
    always_comb begin
        n_entry = r_entry;
        n_live  = r_live;
        unique case (i_cmd.act)
            ACT_SCAN: begin
                // An entry stays live unless it lies past the count or is a copy of the id in the tail.
                n_live = w_in_list && !(w_match && (MY >= i_pos));
            end
            ACT_SWAP: begin
                // Odd-even exchange: a dead slot trades places with a live one above.
                if (PAR == i_cmd.phase) begin
                    if (!r_live && i_next_live) begin
                        n_entry = i_next_entry;
                        n_live  = 1'b1;
                    end
                end else if (!i_prev_live && r_live) begin
                    n_entry = i_prev_entry;
                    n_live  = 1'b0;
                end
            end
            ACT_INSERT: begin
                if (i_pos < i_num) begin
                    if (MY == i_pos) begin
                        n_entry = i_id;
                    end else if ((MY > i_pos) && (MY <= i_num)) begin
                        n_entry = i_prev_entry;
                    end
                end else begin
                    // Insertion past the end zero-fills the gap.
                    if (MY == i_pos) begin
                        n_entry = i_id;
                    end else if ((MY >= i_num) && (MY < i_pos)) begin
                        n_entry = '0;
                    end
                end
            end
            ACT_DELETE: begin
                if ((MY >= i_pos) && (MY_P1 < i_num)) begin
                    n_entry = i_next_entry;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    // Slot storage; contents need no reset.
    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        r_live  <= n_live;
    end

endmodule

// File: hw/rtl/ordered_id_list_engine.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ordered_id_list_engine
// Ordered list of up to DEPTH ids held in a chain of cells, with positional
// insert, delete, tail removal, tail query and clear.
// ---------------------------------------------------------------------------
//  Port   | Dir | Modport | Carries
//  -------+-----+---------+--------------------------------------------
//  i_req  | in  | sink    | opcode, position, id_value
//  o_rsp  | out | source  | found, changed, full_error, entry_count
//
//  An accepted request passes the scan, decide and done states before the next
//  is taken when it only reads or clears, and a shift state ahead of done when
//  it inserts or deletes. Removing tail copies adds DEPTH odd-even exchange
//  rounds and a recount state; insert_only then goes on to the shift state.
//  One request is in work at a time; a new one is taken while the previous
//  response waits, and a finished one waits for the response register.
//  Reset is synchronous and empties the list; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ordered_id_list_engine #(
    parameter int DEPTH   = 16,
    parameter int ID_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    oile_req_if.sink   i_req,
    oile_rsp_if.source o_rsp
);
    import oile_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PW    = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int RW    = $clog2(DEPTH);
    localparam logic [PW-1:0]    DEPTH_P    = PW'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_C    = CNT_W'(DEPTH);
    localparam logic [RW-1:0]    ROUND_LAST = RW'(DEPTH - 1);

    // Sequencer states.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_COMPACT = 3'd3;
    localparam logic [2:0] S_RECOUNT = 3'd4;
    localparam logic [2:0] S_INSERT  = 3'd5;
    localparam logic [2:0] S_DELETE  = 3'd6;
    localparam logic [2:0] S_DONE    = 3'd7;

    logic [2:0]         r_state;
    logic [OP_W-1:0]    r_op;
    logic [PW-1:0]      r_pos;
    logic [ID_BITS-1:0] r_id;
    logic [CNT_W-1:0]   r_count;
    logic [RW-1:0]      r_round;
    logic               r_found;
    logic               r_at_pos;
    logic               r_changed;
    logic               r_full;
    logic               r_then_insert;

    logic               r_out_valid;
    logic               r_out_found;
    logic               r_out_changed;
    logic               r_out_full;
    logic [CNT_W-1:0]   r_out_count;

    t_cell_cmd          w_cmd;
    logic [PW-1:0]      w_num;
    logic [ID_BITS-1:0] w_entry [DEPTH];
    logic [DEPTH-1:0]   w_live;
    logic [DEPTH-1:0]   w_live_up;
    logic [DEPTH-1:0]   w_edge;
    logic [DEPTH-1:0]   w_hit_tail;
    logic [DEPTH-1:0]   w_hit_at;
    logic [CNT_W-1:0]   w_new_count;
    logic               w_ins_full;
    logic               w_out_free;
    logic               w_req_fire;

    assign w_num      = PW'(r_count);
    assign w_req_fire = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Command broadcast to every cell.
    always_comb begin
        w_cmd.phase = r_round[0];
        unique case (r_state)
            S_SCAN:    w_cmd.act = ACT_SCAN;
            S_COMPACT: w_cmd.act = ACT_SWAP;
            S_INSERT:  w_cmd.act = ACT_INSERT;
            S_DELETE:  w_cmd.act = ACT_DELETE;
            default:   w_cmd.act = ACT_HOLD;
        endcase
    end

    // The chain of list cells.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [ID_BITS-1:0] w_prev_entry;
        logic               w_prev_live;
        logic [ID_BITS-1:0] w_next_entry;
        logic               w_next_live;

        if (g == 0) begin : g_first
            assign w_prev_entry = '0;
            assign w_prev_live  = 1'b1;
        end else begin : g_mid_lo
            assign w_prev_entry = w_entry[g-1];
            assign w_prev_live  = w_live[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_next_entry = '0;
            assign w_next_live  = 1'b0;
        end else begin : g_mid_hi
            assign w_next_entry = w_entry[g+1];
            assign w_next_live  = w_live[g+1];
        end

        oile_cell #(
            .ID_BITS (ID_BITS),
            .PW      (PW),
            .IDX     (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_cmd        (w_cmd),
            .i_pos        (r_pos),
            .i_num        (w_num),
            .i_id         (r_id),
            .i_prev_entry (w_prev_entry),
            .i_prev_live  (w_prev_live),
            .i_next_entry (w_next_entry),
            .i_next_live  (w_next_live),
            .o_entry      (w_entry[g]),
            .o_live       (w_live[g]),
            .o_hit_tail   (w_hit_tail[g]),
            .o_hit_at     (w_hit_at[g])
        );
    end

    // After compaction the live flags form a prefix; its edge is the count.
    assign w_live_up = {1'b0, w_live[DEPTH-1:1]};
    assign w_edge    = w_live & ~w_live_up;

    always_comb begin
        w_new_count = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_edge[i]) begin
                w_new_count = w_new_count | CNT_W'(i + 1);
            end
        end
    end

    // Capacity check for an insertion at r_pos into the current list.
    assign w_ins_full = (r_pos < w_num) ? (w_num == DEPTH_P) : (r_pos >= DEPTH_P);

    // Operation sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_round       <= '0;
            r_then_insert <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_req_fire) begin
                        r_op      <= i_req.opcode;
                        r_id      <= ID_BITS'(i_req.id_value);
                        r_changed <= 1'b0;
                        r_full    <= 1'b0;
                        if ((i_req.opcode == OP_APPEND) ||
                            (i_req.opcode == OP_APPEND_ABSENT)) begin
                            r_pos <= '0;
                        end else begin
                            r_pos <= PW'(i_req.position);
                        end
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_found  <= |w_hit_tail;
                    r_at_pos <= |w_hit_at;
                    r_state  <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_state       <= S_DONE;
                    r_then_insert <= 1'b0;
                    r_round       <= '0;
                    unique case (r_op)
                        OP_APPEND, OP_APPEND_ABSENT: begin
                            if (!(r_op == OP_APPEND_ABSENT && r_found)) begin
                                if (w_num == DEPTH_P) begin
                                    r_full <= 1'b1;
                                end else begin
                                    r_pos     <= w_num;
                                    r_changed <= 1'b1;
                                    r_state   <= S_INSERT;
                                end
                            end
                        end
                        OP_INSERT, OP_INSERT_ABSENT: begin
                            if (!(r_op == OP_INSERT_ABSENT && r_found)) begin
                                if (w_ins_full) begin
                                    r_full <= 1'b1;
                                end else begin
                                    r_changed <= 1'b1;
                                    r_state   <= S_INSERT;
                                end
                            end
                        end
                        OP_REMOVE_TAIL: begin
                            if ((r_pos < w_num) && r_found) begin
                                r_changed <= 1'b1;
                                r_state   <= S_COMPACT;
                            end
                        end
                        OP_DELETE: begin
                            if (r_pos < w_num) begin
                                r_changed <= 1'b1;
                                r_state   <= S_DELETE;
                            end
                        end
                        OP_INSERT_ONLY: begin
                            // Already in place: nothing to do.
                            if (!r_at_pos) begin
                                // Copies that would be removed free room first.
                                if ((r_pos < w_num) ? (w_num == DEPTH_P && !r_found)
                                                    : (r_pos >= DEPTH_P)) begin
                                    r_full <= 1'b1;
                                end else begin
                                    r_changed <= 1'b1;
                                    if ((r_pos < w_num) && r_found) begin
                                        r_then_insert <= 1'b1;
                                        r_state       <= S_COMPACT;
                                    end else begin
                                        r_state <= S_INSERT;
                                    end
                                end
                            end
                        end
                        OP_CLEAR: begin
                            r_changed <= (r_count != '0);
                            r_count   <= '0;
                        end
                        default: begin
                            r_state <= S_DONE;
                        end
                    endcase
                end
                S_COMPACT: begin
                    r_round <= r_round + RW'(1);
                    if (r_round == ROUND_LAST) begin
                        r_state <= S_RECOUNT;
                    end
                end
                S_RECOUNT: begin
                    r_count <= w_new_count;
                    r_state <= r_then_insert ? S_INSERT : S_DONE;
                end
                S_INSERT: begin
                    if (r_pos < w_num) begin
                        r_count <= CNT_W'(w_num + PW'(1));
                    end else begin
                        r_count <= CNT_W'(r_pos + PW'(1));
                    end
                    r_state <= S_DONE;
                end
                S_DELETE: begin
                    r_count <= r_count - CNT_W'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Response register: parts the engine from a stalled consumer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && w_out_free) begin
            r_out_found   <= r_found;
            r_out_changed <= r_changed;
            r_out_full    <= r_full;
            r_out_count   <= r_count;
        end
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.changed     = r_out_changed;
    assign o_rsp.full_error  = r_out_full;
    assign o_rsp.entry_count = CNT_O_W'(r_out_count);

    // Checks on the sequencer and the list bookkeeping.
    `OILE_ASSERT(a_count_in_range, r_count <= DEPTH_C, "entry count exceeds capacity")
    `OILE_ASSERT_NEXT(a_accept_to_scan, w_req_fire, r_state == S_SCAN,
        "accepted request did not start a scan")
    `OILE_ASSERT(a_refused_unchanged, !(r_out_valid && r_out_full && r_out_changed),
        "refused operation reported a change")
    `OILE_ASSERT_NEXT(a_recount_shrinks, r_state == S_RECOUNT, r_count < $past(r_count),
        "tail removal did not shrink the list")

endmodule

// File: dv/ordered_id_list_engine_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ordered_id_list_engine_tb
// Self-checking bench for the ordered id list engine. A software copy of the
// list predicts found, changed, full_error and the count for every accepted
// request. Each response is compared against the oldest prediction. A short
// directed sequence covers the corner cases. Random phases follow, with
// different sender gaps and receiver stalls, a long receiver hold-off and
// full drains between phases.
// ---------------------------------------------------------------------------
module ordered_id_list_engine_tb;
    import oile_pkg::*;

    localparam int LIST_DEPTH   = 16;
    localparam int PHASE_ITEMS  = 256;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE_WAIT  = 40;
    localparam int QUIET_LIMIT  = 4000;

    // Status returned for one operation.
    typedef struct packed {
        logic               found;
        logic               changed;
        logic               full_error;
        logic [CNT_O_W-1:0] entry_count;
    } t_list_status;

    // Software copy of the id list; predicts the status of each operation.
    class id_list_checker;
        logic [ID_IN_W-1:0] ids [LIST_DEPTH];
        int unsigned        count;
        t_list_status       pending_status [$];
        int unsigned        errors;

        function new();
            count  = 0;
            errors = 0;
        endfunction

        // Copies of id at index pos or later.
        function int unsigned copies_from(int unsigned pos, logic [ID_IN_W-1:0] id);
            int unsigned n;
            n = 0;
            for (int unsigned i = pos; i < count; i++)
                if (ids[i] == id) n++;
            return n;
        endfunction

        // Count after an insert at pos into a list of num entries.
        function int unsigned grown_count(int unsigned pos, int unsigned num);
            return (pos < num) ? num + 1 : pos + 1;
        endfunction

        // Insert with shift up, or zero-fill up to a position past the end.
        function void insert_at(int unsigned pos, logic [ID_IN_W-1:0] id);
            if (pos < count) begin
                for (int unsigned i = count; i > pos; i--)
                    ids[i] = ids[i-1];
            end else begin
                for (int unsigned i = count; i < pos; i++)
                    ids[i] = '0;
            end
            ids[pos] = id;
            count    = grown_count(pos, count);
        endfunction

        // Drop every copy of id at pos or later and close the gaps.
        function void remove_from(int unsigned pos, logic [ID_IN_W-1:0] id);
            int unsigned w;
            if (pos >= count) return;
            w = pos;
            for (int unsigned r = pos; r < count; r++)
                if (ids[r] != id) begin
                    ids[w] = ids[r];
                    w++;
                end
            count = w;
        endfunction

        // Apply an accepted request and queue the status it should produce.
        function void apply_request(logic [OP_W-1:0] op, logic [POS_W-1:0] pos_in,
                                    logic [ID_IN_W-1:0] id);
            int unsigned  pos;
            int unsigned  num;
            int unsigned  n;
            t_list_status st;
            pos = 32'(pos_in);
            num = count;
            st  = '0;
            // Appends search the whole list.
            if (op == OP_APPEND || op == OP_APPEND_ABSENT) pos = 0;
            st.found = (copies_from(pos, id) != 0);
            case (op)
                OP_APPEND, OP_APPEND_ABSENT: begin
                    if (!(op == OP_APPEND_ABSENT && st.found)) begin
                        if (num + 1 > LIST_DEPTH) begin
                            st.full_error = 1'b1;
                        end else begin
                            insert_at(num, id);
                            st.changed = 1'b1;
                        end
                    end
                end
                OP_INSERT, OP_INSERT_ABSENT: begin
                    if (!(op == OP_INSERT_ABSENT && st.found)) begin
                        if (grown_count(pos, num) > LIST_DEPTH) begin
                            st.full_error = 1'b1;
                        end else begin
                            insert_at(pos, id);
                            st.changed = 1'b1;
                        end
                    end
                end
                OP_REMOVE_TAIL: begin
                    if (pos < num && st.found) begin
                        remove_from(pos, id);
                        st.changed = 1'b1;
                    end
                end
                OP_DELETE: begin
                    if (pos < num) begin
                        for (int unsigned i = pos; i + 1 < num; i++)
                            ids[i] = ids[i+1];
                        count      = num - 1;
                        st.changed = 1'b1;
                    end
                end
                OP_INSERT_ONLY: begin
                    // Nothing to do when the id already sits at the position.
                    if (!(pos < num && ids[pos] == id)) begin
                        // Room is judged after the later copies are gone.
                        n = (pos < num) ? num - copies_from(pos, id) : num;
                        if (grown_count(pos, n) > LIST_DEPTH) begin
                            st.full_error = 1'b1;
                        end else begin
                            remove_from(pos, id);
                            insert_at(pos, id);
                            st.changed = 1'b1;
                        end
                    end
                end
                OP_QUERY_TAIL: begin
                end
                OP_CLEAR: begin
                    st.changed = (num != 0);
                    count      = 0;
                end
                default: begin
                end
            endcase
            st.entry_count = CNT_O_W'(count);
            pending_status.push_back(st);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        // Check one response against the oldest prediction.
        function void check_status(t_list_status got);
            t_list_status want;
            if (pending_status.size() == 0) begin
                errors++;
                $display("%0t: unexpected response: expected none, actual %p", $time, got);
                return;
            end
            want = pending_status.pop_front();
            compare_field("found", 32'(want.found), 32'(got.found));
            compare_field("changed", 32'(want.changed), 32'(got.changed));
            compare_field("full_error", 32'(want.full_error), 32'(got.full_error));
            compare_field("entry_count", 32'(want.entry_count), 32'(got.entry_count));
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    oile_req_if req_if ();
    oile_rsp_if rsp_if ();

    id_list_checker list_chk = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_off_pending;
    int unsigned quiet_cycles;

    ordered_id_list_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 4 ns clock.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Record every accepted request in the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && req_if.valid && req_if.ready)
            list_chk.apply_request(req_if.opcode, req_if.position, req_if.id_value);
    end

    // Check every accepted response.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            list_chk.check_status('{rsp_if.found, rsp_if.changed, rsp_if.full_error,
                                    rsp_if.entry_count});
    end

    // Receiver: random stalls, plus one long hold-off on request.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with random idle cycles ahead of it.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                                input logic [ID_IN_W-1:0] id);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.opcode   <= op;
        req_if.position <= pos;
        req_if.id_value <= id;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // Stop offering and wait until every predicted status has come back.
    // It first waits for a clock edge so that the last accepted request is recorded.
    task automatic drain_list();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (list_chk.pending_status.size() != 0) @(posedge i_clk);
    endtask

    // Ids mostly from a small pool so that duplicates and hits are common.
    function automatic logic [ID_IN_W-1:0] pick_id();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h0000_0001;
            3:       return 32'h8000_0000;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h0000_1234;
            default: return $urandom();
        endcase
    endfunction

    // Operation mix weighted toward inserts and removals.
    function automatic logic [OP_W-1:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 14) return OP_INSERT;
        if (r < 26) return OP_APPEND;
        if (r < 36) return OP_APPEND_ABSENT;
        if (r < 46) return OP_INSERT_ABSENT;
        if (r < 58) return OP_REMOVE_TAIL;
        if (r < 72) return OP_DELETE;
        if (r < 82) return OP_INSERT_ONLY;
        if (r < 90) return OP_QUERY_TAIL;
        if (r < 93) return OP_CLEAR;
        return OP_W'($urandom_range(9, 15));
    endfunction

    // One random phase followed by a full drain.
    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                             input bit with_hold);
        logic [POS_W-1:0] pos;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (with_hold) hold_off_pending = 1'b1;
        repeat (PHASE_ITEMS) begin
            pos = $urandom_range(0, 1) ? POS_W'($urandom_range(0, 15))
                                       : POS_W'($urandom_range(0, 5));
            send_request(pick_op(), pos, pick_id());
        end
        drain_list();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.opcode    = OP_QUERY_TAIL;
        req_if.position  = '0;
        req_if.id_value  = '0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_off_pending = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed corners: empty list, gap fill, full list, in-place and refusals.
        send_request(OP_CLEAR,         4'd0,  32'h0000_0000);
        send_request(OP_QUERY_TAIL,    4'd0,  32'h0000_0000);
        send_request(OP_DELETE,        4'd0,  32'h0000_0000);
        send_request(OP_REMOVE_TAIL,   4'd0,  32'h0000_0000);
        send_request(OP_INSERT,        4'd15, 32'hFFFF_FFFF);
        send_request(OP_APPEND,        4'd3,  32'hAAAA_AAAA);
        send_request(OP_INSERT,        4'd0,  32'h5555_5555);
        send_request(OP_INSERT_ABSENT, 4'd7,  32'hFFFF_FFFF);
        send_request(OP_INSERT_ABSENT, 4'd3,  32'h1234_5678);
        send_request(OP_INSERT_ONLY,   4'd15, 32'hFFFF_FFFF);
        send_request(OP_INSERT_ONLY,   4'd15, 32'h0000_0000);
        send_request(OP_INSERT_ONLY,   4'd1,  32'hFFFF_FFFF);
        send_request(OP_QUERY_TAIL,    4'd2,  32'hFFFF_FFFF);
        send_request(OP_REMOVE_TAIL,   4'd2,  32'h0000_0000);
        send_request(OP_DELETE,        4'd5,  32'h0000_0000);
        send_request(OP_DELETE,        4'd0,  32'h0000_0000);
        send_request(OP_APPEND_ABSENT, 4'd9,  32'hFFFF_FFFF);
        send_request(OP_APPEND_ABSENT, 4'd9,  32'h5555_5555);
        send_request(OP_INSERT_ONLY,   4'd9,  32'hAAAA_AAAA);
        send_request(4'd9,             4'd0,  32'h5555_5555);
        send_request(4'd15,            4'd15, 32'hAAAA_AAAA);
        send_request(OP_CLEAR,         4'd15, 32'hFFFF_FFFF);
        drain_list();

        // Random phases: long hold-off first, then sender gaps, stalls, both.
        run_phase(0, 0, 1'b1);
        run_phase(60, 0, 1'b0);
        run_phase(0, 60, 1'b0);
        run_phase(12, 12, 1'b0);

        // Let any stray response show up before the verdict.
        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (list_chk.errors == 0 && list_chk.pending_status.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
